@@ src/assert_macros.svh @@
// Assertion macros for the convolution block's RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/cpc_pkg.sv @@
// Shared widths, codes and sequencer states of the cyclic convolution block.
package cpc_pkg;

	localparam int IDX_W       = 10;
	localparam int COEF_W      = 16;
	localparam int ACC_W       = 32;
	localparam int LEN_W       = 11;
	localparam int LEN_RESET   = 1024;
	localparam int MAX_LEN_DEF = 1024;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_MAC,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

@@ src/cpc_req_if.sv @@
// Request channel: load and read items into the convolution block.
interface cpc_req_if;
	logic                                valid;
	logic                                ready;
	cpc_pkg::op_t                        op;
	logic [cpc_pkg::IDX_W-1:0]           index;
	logic signed [cpc_pkg::COEF_W-1:0]   first_coeff;
	logic signed [cpc_pkg::COEF_W-1:0]   second_coeff;

	modport source (output valid, op, index, first_coeff, second_coeff, input ready);
	modport sink (input valid, op, index, first_coeff, second_coeff, output ready);
endinterface

@@ src/cpc_rsp_if.sv @@
// Response channel: one product coefficient per read item.
interface cpc_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [cpc_pkg::IDX_W-1:0]         out_index;
	logic signed [cpc_pkg::ACC_W-1:0]  product_coeff;

	modport source (output valid, out_index, product_coeff, input ready);
	modport sink (input valid, out_index, product_coeff, output ready);
endinterface

@@ src/cpc_cfg_if.sv @@
// Configuration write channel carrying the ring length register.
interface cpc_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [cpc_pkg::LEN_W-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ src/cyclic_polynomial_convolution.sv @@
// Cyclic convolution in Z[X]/(X^N-1): load items fill two coefficient stores, read items
// return one product coefficient. A load item gives no result and leaves the block idle.
// A read item keeps the block busy through a 10-step restoring remainder of the position
// by N, then N issues through one shared 16x16 multiply-accumulate, a drain of the read
// and product registers and one result-load state, held while an earlier result waits.
// Async reset clears control and sets N to 1024, not the stores.
`include "assert_macros.svh"

module cyclic_polynomial_convolution #(
	parameter int MAX_LEN = cpc_pkg::MAX_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cpc_req_if.sink    req,
	cpc_rsp_if.source  rsp,
	cpc_cfg_if.sink    cfg
);

	localparam int AW     = $clog2(MAX_LEN);
	localparam int CW     = $clog2(MAX_LEN + 1);
	localparam int IDX_W  = cpc_pkg::IDX_W;
	localparam int COEF_W = cpc_pkg::COEF_W;
	localparam int ACC_W  = cpc_pkg::ACC_W;
	localparam int STEP_W = $clog2(IDX_W);

	cpc_pkg::state_t state_q, state_nx;

	logic [cpc_pkg::LEN_W-1:0] length_q;
	logic [CW-1:0]             n_c, n_q;
	logic [AW-1:0]             nm1_q;
	logic [IDX_W-1:0]          k_q, kshift_q;
	logic [CW-1:0]             rem_q, rem_nx;
	logic [CW:0]               trial;
	logic [STEP_W-1:0]         step_q;
	logic [AW-1:0]             i_q, j_q;
	logic                      rd_valid_s1, prod_valid_s2;
	logic signed [COEF_W-1:0]  a_rd, b_rd;
	logic signed [ACC_W-1:0]   prod_c;
	logic [ACC_W-1:0]          prod_s2, acc_q;
	logic                      rsp_valid_q;
	logic [IDX_W-1:0]          rsp_index_q;
	logic [ACC_W-1:0]          rsp_coeff_q;
	logic                      req_acc, load_we, mac_re, mod_last, mac_last, done_go;

	// Length register, always writable
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= cpc_pkg::LEN_W'(cpc_pkg::LEN_RESET);
		end else if (cfg.valid) begin
			length_q <= cfg.data;
		end
	end

	// Clamp the length into one to MAX_LEN
	always_comb begin
		if (length_q == '0) begin
			n_c = CW'(1);
		end else if (int'(length_q) > MAX_LEN) begin
			n_c = CW'(MAX_LEN);
		end else begin
			n_c = CW'(length_q);
		end
	end

	// Handshake and store writes
	assign req.ready = (state_q == cpc_pkg::ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign load_we   = req_acc && (req.op == cpc_pkg::OP_LOAD) && (int'(req.index) < MAX_LEN);
	assign mac_re    = (state_q == cpc_pkg::ST_MAC);

	cpc_ram #(.WIDTH(COEF_W), .DEPTH(MAX_LEN)) u_first_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (AW'(req.index)),
		.wdata (req.first_coeff),
		.re    (mac_re),
		.raddr (i_q),
		.rdata (a_rd)
	);

	cpc_ram #(.WIDTH(COEF_W), .DEPTH(MAX_LEN)) u_second_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (AW'(req.index)),
		.wdata (req.second_coeff),
		.re    (mac_re),
		.raddr (j_q),
		.rdata (b_rd)
	);

	// One restoring remainder step of the position by N
	assign trial  = {rem_q, kshift_q[IDX_W-1]};
	assign rem_nx = (trial >= {1'b0, n_q}) ? CW'(trial - {1'b0, n_q}) : CW'(trial);

	// Shared multiplier
	assign prod_c = a_rd * b_rd;

	assign mod_last = (step_q == STEP_W'(IDX_W - 1));
	assign mac_last = (i_q == nm1_q);
	assign done_go  = !rsp_valid_q || rsp.ready;

	// Sequencer: next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			cpc_pkg::ST_IDLE: begin
				if (req_acc && (req.op == cpc_pkg::OP_READ)) begin
					state_nx = cpc_pkg::ST_MOD;
				end
			end
			cpc_pkg::ST_MOD: begin
				if (mod_last) begin
					state_nx = cpc_pkg::ST_MAC;
				end
			end
			cpc_pkg::ST_MAC: begin
				if (mac_last) begin
					state_nx = cpc_pkg::ST_DRAIN;
				end
			end
			cpc_pkg::ST_DRAIN: begin
				if (!rd_valid_s1 && !prod_valid_s2) begin
					state_nx = cpc_pkg::ST_DONE;
				end
			end
			cpc_pkg::ST_DONE: begin
				if (done_go) begin
					state_nx = cpc_pkg::ST_IDLE;
				end
			end
			default: state_nx = cpc_pkg::ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= cpc_pkg::ST_IDLE;
			rd_valid_s1   <= 1'b0;
			prod_valid_s2 <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_nx;
			rd_valid_s1   <= mac_re;
			prod_valid_s2 <= rd_valid_s1;
			if (state_q == cpc_pkg::ST_DONE && done_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath: remainder, address walk, multiply-accumulate, result
	always_ff @(posedge clk) begin
		case (state_q)
			cpc_pkg::ST_IDLE: begin
				if (req_acc && (req.op == cpc_pkg::OP_READ)) begin
					k_q      <= req.index;
					kshift_q <= req.index;
					rem_q    <= '0;
					step_q   <= '0;
					n_q      <= n_c;
					nm1_q    <= AW'(n_c - 1'b1);
					acc_q    <= '0;
				end
			end
			cpc_pkg::ST_MOD: begin
				kshift_q <= kshift_q << 1;
				rem_q    <= rem_nx;
				step_q   <= step_q + 1'b1;
				if (mod_last) begin
					i_q <= '0;
					j_q <= AW'(rem_nx);
				end
			end
			cpc_pkg::ST_MAC: begin
				i_q <= i_q + 1'b1;
				j_q <= (j_q == '0) ? nm1_q : j_q - 1'b1;
			end
			cpc_pkg::ST_DONE: begin
				if (done_go) begin
					rsp_index_q <= k_q;
					rsp_coeff_q <= acc_q;
				end
			end
			default: begin
			end
		endcase
		prod_s2 <= ACC_W'(prod_c);
		if (prod_valid_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.out_index     = rsp_index_q;
	assign rsp.product_coeff = rsp_coeff_q;

	// Checks
	`ASSERT_NEXT(a_pipe_adv, rd_valid_s1, prod_valid_s2, "read data not followed by product")
	`ASSERT_IMPLIES(a_done_empty, state_q == cpc_pkg::ST_DONE, !rd_valid_s1 && !prod_valid_s2, "result taken with products in flight")
	`ASSERT_IMPLIES(a_rem_range, state_q == cpc_pkg::ST_MOD, rem_q < n_q, "partial remainder not below N")
	`ASSERT_IMPLIES(a_addr_range, state_q == cpc_pkg::ST_MAC, (i_q <= nm1_q) && (j_q <= nm1_q), "store address beyond ring")
	`ASSERT_NEXT(a_done_rsp, state_q == cpc_pkg::ST_DONE && done_go, rsp.valid, "result not presented after done")

endmodule

@@ src/cpc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cpc_ram #(
	parameter int WIDTH = cpc_pkg::COEF_W,
	parameter int DEPTH = cpc_pkg::MAX_LEN_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ tb/cpc_coeff_checker.sv @@
// Checker for the cyclic convolution block: predicts product coefficients and compares them.
module cpc_coeff_checker (
	input  logic        clk,
	input  logic        arst_n,
	cpc_req_if          req,
	cpc_rsp_if          rsp,
	cpc_cfg_if          cfg,
	output int unsigned fail_count,
	output int unsigned pending_results
);

	typedef struct packed {
		logic [cpc_pkg::IDX_W-1:0] out_index;
		logic [cpc_pkg::ACC_W-1:0] product_coeff;
	} coeff_result_t;

	// Shadow copy of both operand stores and of the ring length
	logic signed [cpc_pkg::COEF_W-1:0] first_coeffs  [cpc_pkg::MAX_LEN_DEF];
	logic signed [cpc_pkg::COEF_W-1:0] second_coeffs [cpc_pkg::MAX_LEN_DEF];
	logic [cpc_pkg::LEN_W-1:0]         ring_len = cpc_pkg::LEN_W'(cpc_pkg::LEN_RESET);

	coeff_result_t expected_coeffs [$];
	int unsigned   mismatch_total = 0;

	initial begin
		fail_count = 0;
		pending_results = 0;
	end

	task automatic report_mismatch(input string what);
		mismatch_total++;
		$display("[coeff check] t=%0t %s", $time, what);
	endtask

	// Sum first[i] * second[(k - i) mod N] over i below N, wrapping at 32 bits
	function automatic coeff_result_t convolve_at(input logic [cpc_pkg::IDX_W-1:0] k);
		coeff_result_t             res;
		int unsigned               n;
		int unsigned               km;
		int unsigned               i;
		int unsigned               j;
		int                        prod;
		logic [cpc_pkg::ACC_W-1:0] acc;
		if (ring_len == 0)
			n = 1;
		else if (ring_len > cpc_pkg::MAX_LEN_DEF)
			n = cpc_pkg::MAX_LEN_DEF;
		else
			n = int'(ring_len);
		km = k % n;
		acc = '0;
		for (i = 0; i < n; i++) begin
			j = (km >= i) ? km - i : km + n - i;
			prod = int'(first_coeffs[i]) * int'(second_coeffs[j]);
			acc += cpc_pkg::ACC_W'(prod);
		end
		res.out_index = k;
		res.product_coeff = acc;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		coeff_result_t want;
		if (!arst_n) begin
			ring_len = cpc_pkg::LEN_W'(cpc_pkg::LEN_RESET);
			expected_coeffs.delete();
		end else begin
			// Compare each accepted result with the oldest expectation
			if (rsp.valid && rsp.ready) begin
				if (expected_coeffs.size() == 0) begin
					report_mismatch($sformatf("result with nothing expected: index %0d value %0d",
						rsp.out_index, rsp.product_coeff));
				end else begin
					want = expected_coeffs.pop_front();
					if (rsp.out_index !== want.out_index)
						report_mismatch($sformatf("out_index %0d, expected %0d",
							rsp.out_index, want.out_index));
					if (rsp.product_coeff !== want.product_coeff)
						report_mismatch($sformatf("product_coeff %0d at index %0d, expected %0d",
							rsp.product_coeff, want.out_index, $signed(want.product_coeff)));
				end
			end
			// Store loads, predict reads
			if (req.valid && req.ready) begin
				if (req.op == cpc_pkg::OP_LOAD) begin
					first_coeffs[req.index] = req.first_coeff;
					second_coeffs[req.index] = req.second_coeff;
				end else begin
					expected_coeffs.push_back(convolve_at(req.index));
				end
			end
			if (cfg.valid && cfg.ready)
				ring_len = cfg.data;
		end
		fail_count <= mismatch_total;
		pending_results <= expected_coeffs.size();
	end

endmodule

@@ tb/tb_cyclic_polynomial_convolution.sv @@
// Testbench top for the cyclic convolution block: stimulus, receiver stalls and verdict.
module tb_cyclic_polynomial_convolution;

	localparam int RANDOM_ITEMS  = 540;
	localparam int SETTLE_CYCLES = 20;
	localparam int DRAIN_LIMIT   = 4000;
	localparam logic signed [cpc_pkg::COEF_W-1:0] COEF_MIN = 16'sh8000;
	localparam logic signed [cpc_pkg::COEF_W-1:0] COEF_MAX = 16'sh7FFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        rsp_ready = 1'b0;
	logic [9:0]  stall_phase = '0;
	int unsigned chk_fails;
	int unsigned chk_pending;
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;
	bit          loaded [cpc_pkg::MAX_LEN_DEF];

	cpc_req_if req_ch ();
	cpc_rsp_if rsp_ch ();
	cpc_cfg_if cfg_ch ();

	cyclic_polynomial_convolution dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	cpc_coeff_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req_ch),
		.rsp             (rsp_ch),
		.cfg             (cfg_ch),
		.fail_count      (chk_fails),
		.pending_results (chk_pending)
	);

	assign rsp_ch.ready = rsp_ready;

	always #6 clk = ~clk;

	// Receiver: cycle through free-running, random and periodic stall modes
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1'b1;
		case (stall_phase[9:8])
			2'd0: rsp_ready <= 1'b1;
			2'd1: rsp_ready <= ($urandom_range(0, 3) != 0);
			2'd2: rsp_ready <= (stall_phase[3:0] < 4'd5);
			default: rsp_ready <= ($urandom_range(0, 1) != 0);
		endcase
	end

	function automatic logic signed [cpc_pkg::COEF_W-1:0] rand_coeff();
		case ($urandom_range(0, 9))
			0: return COEF_MIN;
			1: return COEF_MAX;
			2: return '0;
			3: return '1;
			default: return cpc_pkg::COEF_W'($urandom);
		endcase
	endfunction

	function automatic int unsigned ring_size(input logic [cpc_pkg::LEN_W-1:0] len);
		if (len == 0)
			return 1;
		if (len > cpc_pkg::MAX_LEN_DEF)
			return cpc_pkg::MAX_LEN_DEF;
		return int'(len);
	endfunction

	// Present one item, possibly inserting a gap at the start of each burst
	task automatic issue_request(input cpc_pkg::op_t op, input logic [cpc_pkg::IDX_W-1:0] idx,
			input logic signed [cpc_pkg::COEF_W-1:0] a,
			input logic signed [cpc_pkg::COEF_W-1:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.index <= idx;
		req_ch.first_coeff <= a;
		req_ch.second_coeff <= b;
		do @(posedge clk); while (!req_ch.ready);
		if (op == cpc_pkg::OP_LOAD)
			loaded[idx] = 1'b1;
		items_sent++;
	endtask

	task automatic load_pair(input int unsigned idx, input logic signed [cpc_pkg::COEF_W-1:0] a,
			input logic signed [cpc_pkg::COEF_W-1:0] b);
		issue_request(cpc_pkg::OP_LOAD, cpc_pkg::IDX_W'(idx), a, b);
	endtask

	task automatic read_coeff(input int unsigned k);
		issue_request(cpc_pkg::OP_READ, cpc_pkg::IDX_W'(k), rand_coeff(), rand_coeff());
	endtask

	// Hold off the sender until every expected result has come, then settle
	task automatic wait_idle(input int unsigned settle);
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (chk_pending != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_length(input logic [cpc_pkg::LEN_W-1:0] len);
		wait_idle(SETTLE_CYCLES);
		cfg_ch.data <= len;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// Write every store entry below n that has not been written since reset
	task automatic fill_below(input int unsigned n);
		int unsigned idx;
		for (idx = 0; idx < n; idx++)
			if (!loaded[idx])
				load_pair(idx, rand_coeff(), rand_coeff());
	endtask

	initial begin
		int unsigned               n;
		int unsigned               phase_items;
		int unsigned               random_end;
		int unsigned               wait_cycles;
		int unsigned               item;
		logic [cpc_pkg::LEN_W-1:0] len;
		req_ch.valid <= 1'b0;
		req_ch.op <= cpc_pkg::OP_LOAD;
		req_ch.index <= '0;
		req_ch.first_coeff <= '0;
		req_ch.second_coeff <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single-entry ring, most negative square, read past N
		set_length(11'd1);
		load_pair(0, COEF_MIN, COEF_MIN);
		read_coeff(0);
		read_coeff(1023);
		// Load beyond N must not change the sum
		load_pair(1023, COEF_MAX, COEF_MAX);
		read_coeff(512);
		// Length zero acts as one
		set_length(11'd0);
		read_coeff(1);
		// Two entries: both rotations and a read past N
		set_length(11'd2);
		load_pair(1, COEF_MAX, -16'sd1);
		read_coeff(0);
		read_coeff(1);
		read_coeff(1023);
		// Four products of 2^30 wrap to zero
		set_length(11'd4);
		load_pair(0, COEF_MIN, COEF_MIN);
		load_pair(1, COEF_MIN, COEF_MIN);
		load_pair(2, COEF_MIN, COEF_MIN);
		load_pair(3, COEF_MIN, COEF_MIN);
		read_coeff(2);
		load_pair(1, '0, COEF_MAX);
		read_coeff(3);
		load_pair(0, COEF_MAX, COEF_MAX);
		read_coeff(0);

		// Random phases, each at a fresh ring length
		random_end = items_sent + RANDOM_ITEMS;
		while (items_sent < random_end) begin
			case ($urandom_range(0, 15))
				0: len = '0;
				1: len = 11'd1;
				2: len = 11'd2;
				3: len = cpc_pkg::LEN_W'($urandom_range(64, 160));
				default: len = cpc_pkg::LEN_W'($urandom_range(3, 40));
			endcase
			n = ring_size(len);
			set_length(len);
			fill_below(n);
			phase_items = $urandom_range(15, 50);
			for (item = 0; item < phase_items; item++) begin
				if ($urandom_range(0, 39) == 0)
					wait_idle(0);
				if ($urandom_range(0, 9) < 4)
					read_coeff(($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
						: $urandom_range(0, n - 1));
				else
					load_pair(($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
						: $urandom_range(0, n - 1), rand_coeff(), rand_coeff());
			end
		end

		// Drain outstanding results, then let the block settle
		req_ch.valid <= 1'b0;
		@(posedge clk);
		for (wait_cycles = 0; chk_pending != 0 && wait_cycles < DRAIN_LIMIT; wait_cycles++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (chk_fails == 0 && chk_pending == 0)
			$display("cyclic_polynomial_convolution: match");
		else
			$display("cyclic_polynomial_convolution: mismatch");
		$finish;
	end

	// Watchdog
	initial begin
		#100_000_000;
		$display("cyclic_polynomial_convolution: mismatch");
		$finish;
	end

endmodule
